### sv/four_word_arx_permutation_defines.svh
// Assertion macros for the permutation pipeline.
`ifndef FOUR_WORD_ARX_PERMUTATION_DEFINES_SVH
`define FOUR_WORD_ARX_PERMUTATION_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FAWP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FAWP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/fawp_pkg.sv
package fawp_pkg;

   localparam int unsigned ROUND_COUNT_DEF = 2;
   localparam int unsigned WORD_WIDTH      = 32;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } block_type;

   typedef enum logic {
      PHASE_MIX    = 1'b0,
      PHASE_CHOICE = 1'b1
   } phase_type;

   localparam int unsigned ROT_MIX_A = 1;
   localparam int unsigned ROT_MIX_B = 3;
   localparam int unsigned ROT_MIX_C = 5;
   localparam int unsigned ROT_MIX_D = 7;
   localparam int unsigned ROT_CH_A  = 11;
   localparam int unsigned ROT_CH_B  = 17;
   localparam int unsigned ROT_CH_C  = 23;
   localparam int unsigned ROT_CH_D  = 29;

   function automatic word_type rotl_w(word_type x, int unsigned n);
      logic [2*WORD_WIDTH-1:0] dbl;
      dbl = {x, x} << n;
      return dbl[2*WORD_WIDTH-1:WORD_WIDTH];
   endfunction

   function automatic word_type pick(word_type p, word_type q, word_type r);
      return r ^ (p & (q ^ r));
   endfunction

   function automatic word_type mix_word(word_type x, word_type t, int unsigned n);
      word_type y;
      y = x ^ t;
      y = y ^ ((y & t) << 1);
      return rotl_w(y, n);
   endfunction

endpackage

### sv/fawp_stage.sv
module fawp_stage #(
   parameter fawp_pkg::phase_type PHASE = fawp_pkg::PHASE_MIX
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  fawp_pkg::block_type in_block,
   output logic                out_valid,
   output fawp_pkg::block_type out_block
);
   import fawp_pkg::*;

   logic      valid_ff;
   block_type block_ff;
   block_type block_in;

   generate
      if (PHASE == PHASE_MIX) begin : g_mix
         always_comb begin
            word_type a, b, c, d;
            a = mix_word(in_block.a, in_block.b ^ in_block.c ^ in_block.d, ROT_MIX_A);
            b = mix_word(in_block.b, a ^ in_block.c ^ in_block.d, ROT_MIX_B);
            c = mix_word(in_block.c, a ^ b ^ in_block.d, ROT_MIX_C);
            d = mix_word(in_block.d, a ^ b ^ c, ROT_MIX_D);
            block_in = '{a: a, b: b, c: c, d: d};
         end
      end else begin : g_choice
         always_comb begin
            word_type a, b, c, d;
            a = rotl_w(in_block.a ^ pick(in_block.b, in_block.c, in_block.d), ROT_CH_A);
            b = rotl_w(in_block.b ^ pick(in_block.c, in_block.d, a), ROT_CH_B);
            c = rotl_w(in_block.c ^ pick(in_block.d, a, b), ROT_CH_C);
            d = rotl_w(in_block.d ^ pick(a, b, c), ROT_CH_D);
            block_in = '{a: a, b: b, c: c, d: d};
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

### sv/four_word_arx_permutation.sv
// Four-word ARX permutation of a 128-bit block, pipelined.
// Input channel: req_valid / req_stall with the four words req_in_word_a..d.
// Result channel: rsp_valid / rsp_stall with the permuted words rsp_out_word_a..d.
// A transaction moves at a rising edge with valid high and stall low.
// From an input transaction to rsp_valid a block passes a capture register
// loaded at the accepting edge, then one register after each half round of
// four word updates. Throughput: one transaction per cycle while rsp_stall is low.
// Each stage holds its contents only while the stage after it is full and
// cannot advance, so empty slots close up under a stall and req_stall rises
// only when every stage holds a transaction and rsp_stall is high.
// A stalled result holds its words until taken.
// Reset clears all valid bits; the pipeline comes out of reset empty and
// ready to accept a transaction in the next cycle.
module four_word_arx_permutation #(
   parameter int unsigned ROUND_COUNT = fawp_pkg::ROUND_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fawp_pkg::word_type   req_in_word_a,
   input  fawp_pkg::word_type   req_in_word_b,
   input  fawp_pkg::word_type   req_in_word_c,
   input  fawp_pkg::word_type   req_in_word_d,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fawp_pkg::word_type   rsp_out_word_a,
   output fawp_pkg::word_type   rsp_out_word_b,
   output fawp_pkg::word_type   rsp_out_word_c,
   output fawp_pkg::word_type   rsp_out_word_d
);
   import fawp_pkg::*;

`include "four_word_arx_permutation_defines.svh"

   localparam int unsigned LAST = 2 * ROUND_COUNT;

   logic      stage_valid [0:LAST];
   block_type stage_block [0:LAST];
   logic      stage_ready [0:LAST];

   logic      cap_valid_ff;
   block_type cap_block_ff;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      stage_ready[LAST] = !stage_valid[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else if (stage_ready[0]) begin
         cap_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         cap_block_ff <= '{a: req_in_word_a, b: req_in_word_b,
                           c: req_in_word_c, d: req_in_word_d};
      end
   end

   assign stage_valid[0] = cap_valid_ff;
   assign stage_block[0] = cap_block_ff;

   generate
      for (genvar k = 1; k <= LAST; k++) begin : g_stage
         fawp_stage #(
            .PHASE(((k % 2) == 1) ? PHASE_MIX : PHASE_CHOICE)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .advance  (stage_ready[k]),
            .in_valid (stage_valid[k-1]),
            .in_block (stage_block[k-1]),
            .out_valid(stage_valid[k]),
            .out_block(stage_block[k])
         );
      end
   endgenerate

   assign req_stall      = !stage_ready[0];
   assign rsp_valid      = stage_valid[LAST];
   assign rsp_out_word_a = stage_block[LAST].a;
   assign rsp_out_word_b = stage_block[LAST].b;
   assign rsp_out_word_c = stage_block[LAST].c;
   assign rsp_out_word_d = stage_block[LAST].d;

   `FAWP_ASSERT(a_stall_needs_full_out, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled while output can drain")
   `FAWP_ASSERT(a_free_out_takes_input, clock, reset, !rsp_stall |-> !req_stall, "input stalled with output not stalled")
   `FAWP_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule
